// ===== rtl/rmmsq_pkg.sv =====
// Package for the range min/max/sum query block: field widths, codes and
// the node combine function. No dependencies.
`default_nettype none

package rmmsq_pkg;

  localparam int VAL_W      = 32;  // element value width
  localparam int RES_W      = 42;  // node / result width
  localparam int POS_W      = 10;  // element index field width
  localparam int CNT_W      = 11;  // elem_count register width
  localparam int MODE_W     = 2;   // combine_mode register width
  localparam int IDX_W      = 1;   // config register index width
  localparam int CFG_W      = 11;  // config write data width
  localparam int IN_DATA_W  = 64;  // packed input tdata, padded to bytes
  localparam int OUT_DATA_W = 48;  // packed result tdata, padded to bytes

  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [IDX_W-1:0] REG_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_MIN;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;

  typedef logic signed [RES_W-1:0] node_t;

  // Combine two nodes under the current mode; unused mode code acts as sum.
  function automatic node_t combine_nodes(input logic [MODE_W-1:0] mode,
                                          input node_t a, input node_t b);
    node_t r;
    case (mode)
      MODE_MIN: r = (a < b) ? a : b;
      MODE_MAX: r = (a > b) ? a : b;
      default:  r = a + b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/range_min_max_sum_query.sv =====
// Top level of the range min/max/sum query block (segment tree in one
// node memory with two read ports). Depends on rmmsq_pkg.
`default_nettype none

// Channel   Dir  Handshake          Payload
// in_       in   in_tvalid/tready   tuser: kind; tdata: position, load_value,
//                                   left_end, right_end
// out_      out  out_tvalid/tready  tuser: range_error; tdata: range_result
// cfg_      in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// Flow: a load writes the leaf, then updates one tree level per cycle
// through the single write port. A query makes one pass per tree level it
// walks, each issuing up to two node reads, then a two-stage combine pipe
// drains. A bad range skips the walk and goes straight to the output state.
// Reset: control state only; node memory is undefined until loaded.
// A combine_mode write rebuilds all internal nodes with in_tready low.
// One item is in work at a time; a result waiting in the output register
// does not block the next accept.
module range_min_max_sum_query
  import rmmsq_pkg::*;
#(
  parameter int MAX_ELEMS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [9:0] position, [41:10] load_value, [51:42] left_end,
  // [61:52] right_end, [63:62] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [41:0] range_result, [47:42] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] range_error
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  // Memory address width, tree pointer width (holds 2*MAX_ELEMS),
  // and a compare width wide enough for counts and field values.
  localparam int AW = $clog2(2 * MAX_ELEMS);
  localparam int HW = AW + 1;
  localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int DEPTH = 2 * MAX_ELEMS;

  localparam logic [XW-1:0] MAX_X = XW'(MAX_ELEMS);
  localparam logic [AW-1:0] MAX_A = AW'(MAX_ELEMS);
  localparam logic [AW-1:0] ROOT_A = AW'(1);
  localparam logic [AW-1:0] LAST_INNER = AW'(MAX_ELEMS - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_QRY    = 7'b0000100,
    ST_QDRAIN = 7'b0001000,
    ST_QOUT   = 7'b0010000,
    ST_RB_RD  = 7'b0100000,
    ST_RB_WR  = 7'b1000000
  } state_t;

  // Input field split
  logic [POS_W-1:0] f_position;
  logic [VAL_W-1:0] f_load_value;
  logic [POS_W-1:0] f_left;
  logic [POS_W-1:0] f_right;
  assign f_position   = in_tdata[9:0];
  assign f_load_value = in_tdata[41:10];
  assign f_left       = in_tdata[51:42];
  assign f_right      = in_tdata[61:52];

  // Control registers
  state_t             state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r, out_valid_nxt;
  logic               ra_v_r, rb_v_r, pair_v_r, acc_v_r;
  logic               acc_v_nxt;

  // Payload registers
  node_t              out_res_r, out_res_nxt;
  logic               out_err_r, out_err_nxt;
  logic               err_r, err_nxt;
  node_t              cur_r, cur_nxt;          // value carried up a load path
  logic [AW-1:0]      node_r, node_nxt;        // load path node / rebuild node
  logic [HW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  node_t              pair_r, acc_r, acc_nxt;

  // Node memory: one write port, two registered read ports
  node_t              node_mem [DEPTH];
  node_t              rd_a_r, rd_b_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  node_t              mem_wd;
  logic               ren_a, ren_b;
  logic [AW-1:0]      ra_addr, rb_addr;
  logic               q_rd_a, q_rd_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    if (ren_a) begin
      rd_a_r <= node_mem[ra_addr];
    end
    if (ren_b) begin
      rd_b_r <= node_mem[rb_addr];
    end
  end

  // Accept decode
  logic               in_fire, mode_wr;
  logic [XW-1:0]      count_x, left_x, right_x;
  logic               load_ok, bad_range;
  node_t              load_sext;
  logic [AW-1:0]      leaf_a, parent_a, hi_m1;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mode_wr   = cfg_we && (cfg_index == REG_MODE);

  assign count_x   = (XW'(count_r) > MAX_X) ? MAX_X : XW'(count_r);
  assign left_x    = XW'(f_left);
  assign right_x   = XW'(f_right);
  assign bad_range = (left_x > right_x) || (right_x >= count_x);
  assign load_ok   = XW'(f_position) < MAX_X;
  assign load_sext = {{(RES_W-VAL_W){f_load_value[VAL_W-1]}}, f_load_value};
  assign leaf_a    = MAX_A + AW'(f_position);
  assign parent_a  = node_r >> 1;
  assign hi_m1     = AW'(hi_r - HW'(1));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    err_nxt       = err_r;
    cur_nxt       = cur_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mem_we        = 1'b0;
    mem_wa        = node_r;
    mem_wd        = cur_r;
    ren_a         = 1'b0;
    ren_b         = 1'b0;
    ra_addr       = node_r;
    rb_addr       = node_r;
    q_rd_a        = 1'b0;
    q_rd_b        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == KIND_LOAD) begin
            if (load_ok) begin
              // write the leaf and fetch its sibling in the same cycle
              mem_we    = 1'b1;
              mem_wa    = leaf_a;
              mem_wd    = load_sext;
              ren_a     = 1'b1;
              ra_addr   = {leaf_a[AW-1:1], ~leaf_a[0]};
              cur_nxt   = load_sext;
              node_nxt  = leaf_a;
              state_nxt = ST_LOAD;
            end
          end else begin
            err_nxt = bad_range;
            lo_nxt  = HW'(MAX_ELEMS) + HW'(f_left);
            hi_nxt  = HW'(MAX_ELEMS) + HW'(f_right) + HW'(1);
            state_nxt = bad_range ? ST_QOUT : ST_QRY;
          end
        end
      end
      ST_LOAD: begin
        // one level per cycle: parent = cur op sibling
        mem_we   = 1'b1;
        mem_wa   = parent_a;
        mem_wd   = combine_nodes(mode_r, cur_r, rd_a_r);
        cur_nxt  = mem_wd;
        node_nxt = parent_a;
        if (parent_a == ROOT_A) begin
          state_nxt = ST_IDLE;
        end else begin
          ren_a   = 1'b1;
          ra_addr = {parent_a[AW-1:1], ~parent_a[0]};
        end
      end
      ST_QRY: begin
        if (lo_r < hi_r) begin
          q_rd_a  = lo_r[0];
          q_rd_b  = hi_r[0];
          ren_a   = q_rd_a;
          ra_addr = lo_r[AW-1:0];
          ren_b   = q_rd_b;
          rb_addr = hi_m1;
          lo_nxt  = (lo_r + HW'(lo_r[0])) >> 1;
          hi_nxt  = hi_r >> 1;
        end else begin
          state_nxt = ST_QDRAIN;
        end
      end
      ST_QDRAIN: begin
        if (!ra_v_r && !rb_v_r && !pair_v_r) begin
          state_nxt = ST_QOUT;
        end
      end
      ST_QOUT: begin
        // waits only while a previous result is still unclaimed
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = err_r ? '0 : acc_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RB_RD: begin
        ren_a     = 1'b1;
        ra_addr   = {node_r[AW-2:0], 1'b0};
        ren_b     = 1'b1;
        rb_addr   = {node_r[AW-2:0], 1'b1};
        state_nxt = ST_RB_WR;
      end
      ST_RB_WR: begin
        mem_we = 1'b1;
        mem_wa = node_r;
        mem_wd = combine_nodes(mode_r, rd_a_r, rd_b_r);
        if (node_r == ROOT_A) begin
          state_nxt = ST_IDLE;
        end else begin
          node_nxt  = node_r - AW'(1);
          state_nxt = ST_RB_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // mode change: rebuild every inner node bottom-up, restarting if needed
    if (mode_wr) begin
      node_nxt  = LAST_INNER;
      state_nxt = ST_RB_RD;
    end
  end

  // Combine pipe: read data -> pair of this level -> running accumulator
  always_comb begin
    acc_nxt   = acc_r;
    acc_v_nxt = acc_v_r;
    if (in_fire) begin
      acc_v_nxt = 1'b0;
    end else if (pair_v_r) begin
      acc_nxt   = acc_v_r ? combine_nodes(mode_r, acc_r, pair_r) : pair_r;
      acc_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ra_v_r && rb_v_r) begin
      pair_r <= combine_nodes(mode_r, rd_a_r, rd_b_r);
    end else if (ra_v_r) begin
      pair_r <= rd_a_r;
    end else begin
      pair_r <= rd_b_r;
    end
    acc_r     <= acc_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
    err_r     <= err_nxt;
    cur_r     <= cur_nxt;
    node_r    <= node_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RESET;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
      ra_v_r      <= 1'b0;
      rb_v_r      <= 1'b0;
      pair_v_r    <= 1'b0;
      acc_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ra_v_r      <= q_rd_a;
      rb_v_r      <= q_rd_b;
      pair_v_r    <= ra_v_r || rb_v_r;
      acc_v_r     <= acc_v_nxt;
      if (mode_wr) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_COUNT)) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-RES_W)'(0), out_res_r};
  assign out_tuser  = out_err_r;

`ifndef SYNTHESIS
  // An error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result with nonzero data");

  // Query range pointers never cross while reads are issued
  a_lo_hi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_QRY |-> lo_r <= hi_r)
    else $error("query pointers crossed");

  // A mode write blocks input for the rebuild
  a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    mode_wr |=> !in_tready)
    else $error("input open during rebuild");

  // A load walk stops at the root
  a_load_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> node_r != '0)
    else $error("load walk passed the root");

  // Result is produced only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_QOUT)
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_range_min_max_sum_query.sv =====
// Self-checking testbench for range_min_max_sum_query (segment tree range
// min/max/sum). Depends on rmmsq_pkg and the block's RTL only; predicts every
// query answer from its own copy of the loaded elements and the registers.
`timescale 1ns / 1ps

module tb_range_min_max_sum_query
  import rmmsq_pkg::*;
();

  localparam int TREE_LEAVES    = 1024;   // MAX_ELEMS of the instance
  localparam int ITEM_TARGET    = 1150;   // stimulus stops after this many items
  localparam int SETTLE_CYCLES  = 32;     // outlasts a load's walk up the tree
  localparam int WATCHDOG_LIMIT = 20000;  // covers a full rebuild plus long stalls
  localparam int LONG_HOLD      = 400;    // receiver hold-off, in cycles

  // Sum has no name in the package; the spare code also sums.
  localparam logic [MODE_W-1:0] MODE_SUM   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // ---------------------------------------------------------------------------
  // Answer tracker: mirrors the element values and registers, and keeps the
  // answers still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  class range_answer_tracker;
    typedef struct {
      node_t total;
      logic  bad_range;
    } answer_t;

    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    node_t             leaf_value [TREE_LEAVES];
    answer_t           awaited_answers [$];
    int                mismatches;
    int                checked;

    function new();
      mode       = MODE_RESET;
      count      = COUNT_RESET;
      mismatches = 0;
      checked    = 0;
      foreach (leaf_value[i]) leaf_value[i] = '0;
    endfunction

    function void write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      // A mode write rebuilds the tree in the block; aggregating straight
      // from the leaves gives the same answers.
      if (idx == REG_MODE) mode = value[MODE_W-1:0];
      else count = value[CNT_W-1:0];
    endfunction

    function void note_item(input logic kind, input logic [IN_DATA_W-1:0] data);
      int      left_idx, right_idx, usable;
      node_t   acc;
      answer_t ans;
      if (kind == KIND_LOAD) begin
        leaf_value[data[9:0]] = node_t'($signed(data[41:10]));
        return;
      end
      left_idx  = data[51:42];
      right_idx = data[61:52];
      usable    = (count > TREE_LEAVES) ? TREE_LEAVES : count;
      if (left_idx > right_idx || right_idx >= usable) begin
        ans.total     = '0;
        ans.bad_range = 1'b1;
      end else begin
        acc = leaf_value[left_idx];
        for (int i = left_idx + 1; i <= right_idx; i++) begin
          case (mode)
            MODE_MIN: if (leaf_value[i] < acc) acc = leaf_value[i];
            MODE_MAX: if (leaf_value[i] > acc) acc = leaf_value[i];
            default:  acc = acc + leaf_value[i];   // wraps at 42 bits
          endcase
        end
        ans.total     = acc;
        ans.bad_range = 1'b0;
      end
      awaited_answers.push_back(ans);
    endfunction

    function void check_answer(input logic [OUT_DATA_W-1:0] data, input logic flag);
      answer_t want;
      node_t   got;
      got = data[RES_W-1:0];
      if (awaited_answers.size() == 0) begin
        $error("unexpected result: range_result=%0d range_error=%0b", got, flag);
        mismatches++;
        return;
      end
      want = awaited_answers.pop_front();
      checked++;
      if (got !== want.total) begin
        $error("range_result: expected %0d, got %0d", want.total, got);
        mismatches++;
      end
      if (flag !== want.bad_range) begin
        $error("range_error: expected %0b, got %0b", want.bad_range, flag);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [9:0] position, [41:10] load_value,
                                          // [51:42] left_end, [61:52] right_end
  logic                  in_tuser = 1'b0; // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [41:0] range_result
  logic                  out_tuser;       // [0] range_error
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  range_min_max_sum_query #(.MAX_ELEMS(TREE_LEAVES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  range_answer_tracker answers = new();

  // Stimulus-side bookkeeping
  bit loaded [TREE_LEAVES];   // elements written since reset; queries stay inside
  int cur_usable = TREE_LEAVES;
  int burst_left = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int bad_sent = 0;
  int settings_used = 0;
  int hold_cycles = 0;        // set by the main thread, counted down by the receiver
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Monitors: handshakes are sampled at the edge, before any NBA lands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) answers.note_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) answers.check_answer(out_tdata, out_tuser);
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d answers outstanding",
               idle_cycles, answers.awaited_answers.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall density changes at random from pattern to pattern (zero included);
  // a requested hold-off keeps tready low for a counted stretch.
  initial begin : receiver
    int pattern_left;
    int stall_pct;
    pattern_left = 0;
    stall_pct    = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge it is taken. Items go out in
  // bursts; a new burst may start after a gap with tvalid low.
  task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] payload);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Unused fields of each kind carry random bits.
  task automatic send_load(input int pos, input logic signed [31:0] value);
    loaded[pos] = 1'b1;
    loads_sent++;
    send_item(KIND_LOAD, {2'b00, 10'($urandom), 10'($urandom), value, 10'(pos)});
  endtask

  task automatic send_query(input int left_idx, input int right_idx);
    queries_sent++;
    if (left_idx > right_idx || right_idx >= cur_usable) bad_sent++;
    send_item(KIND_QUERY,
              {2'b00, 10'(right_idx), 10'(left_idx), 32'($urandom), 10'($urandom)});
  endtask

  // Drop tvalid, wait for every owed answer, then let a trailing load finish.
  // One edge first so the monitor has logged the last accepted item.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (answers.awaited_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Count first, then mode: the mode write starts the tree rebuild, which
  // holds in_tready low until it is done.
  task automatic program_block(input logic [CNT_W-1:0] count, input logic [MODE_W-1:0] mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COUNT;
    cfg_wdata <= CFG_W'(count);
    answers.write_reg(REG_COUNT, CFG_W'(count));
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_wdata <= CFG_W'(mode);
    answers.write_reg(REG_MODE, CFG_W'(mode));
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_usable = (count > TREE_LEAVES) ? TREE_LEAVES : count;
    settings_used++;
  endtask

  // Element values lean on the extremes so sums and compares hit the edges.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int phase;
    int pos, left_idx, right_idx, run_end;
    logic [CNT_W-1:0]  count_pick;
    logic [MODE_W-1:0] mode_pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme values at both ends of the tree, every mode,
    // reversed and out-of-count ranges, zero and oversize counts.
    program_block(11'd1024, MODE_MIN);
    send_load(0, 32'sh8000_0000);
    send_load(1, 32'sh7fff_ffff);
    send_load(2, 32'sh0000_0000);
    send_load(3, 32'shffff_ffff);
    send_load(1022, 32'sh8000_0000);
    send_load(1023, 32'sh7fff_ffff);
    send_query(0, 0);
    send_query(0, 3);
    send_query(1, 2);
    send_query(1022, 1023);
    send_query(1023, 1023);
    send_query(3, 2);          // left past right
    settle();
    program_block(11'd1024, MODE_MAX);
    send_query(0, 3);
    send_query(1022, 1023);
    settle();
    program_block(11'd2047, MODE_SUM);   // oversize count acts as the full tree
    send_query(0, 3);
    send_query(1023, 1023);
    settle();
    program_block(11'd4, MODE_SPARE);    // spare mode code sums
    send_query(0, 4);          // right end reaches the count
    send_query(2, 3);
    send_load(10, 32'sd5);     // past the count, still stored
    settle();
    program_block(11'd0, MODE_MIN);      // zero count: every query is a bad range
    send_query(0, 0);
    settle();

    // Random phases: new count and mode, then a mix of loads that grow
    // contiguous loaded runs and queries inside them, plus bad ranges.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      case ($urandom_range(0, 9))
        0: count_pick = 11'd1;
        1: count_pick = 11'd1024;
        2: count_pick = 11'd0;
        3: count_pick = CNT_W'($urandom_range(1025, 2047));
        4: count_pick = CNT_W'($urandom_range(301, 1023));
        default: count_pick = CNT_W'($urandom_range(2, 300));
      endcase
      mode_pick = MODE_W'($urandom_range(0, 3));
      program_block(count_pick, mode_pick);

      // Long receiver hold-off while items keep coming: the output register
      // fills and the block has to stall its input.
      if (phase == 3 || phase == 12) hold_cycles = LONG_HOLD;

      repeat ($urandom_range(25, 70)) begin
        if ($urandom_range(0, 99) < 40) begin
          pos = $urandom_range(0, TREE_LEAVES - 1);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              // extend the loaded prefix: lowest unloaded element in use
              if (cur_usable > 0) pos = $urandom_range(0, cur_usable - 1);
              for (int i = cur_usable - 1; i >= 0; i--) if (!loaded[i]) pos = i;
            end
            9: ;   // anywhere, often past the count
            default: if (cur_usable > 0) pos = $urandom_range(0, cur_usable - 1);
          endcase
          send_load(pos, pick_value());
        end else if (cur_usable == 0 || $urandom_range(0, 99) < 15) begin
          if (cur_usable < TREE_LEAVES && $urandom_range(0, 1) == 1) begin
            right_idx = $urandom_range(cur_usable, TREE_LEAVES - 1);
            left_idx  = $urandom_range(0, right_idx);
          end else begin
            left_idx  = $urandom_range(1, TREE_LEAVES - 1);
            right_idx = $urandom_range(0, left_idx - 1);
          end
          send_query(left_idx, right_idx);
        end else begin
          left_idx = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cur_usable - 1);
          if (!loaded[left_idx]) begin
            // never query an element that was not written; write it instead
            send_load(left_idx, pick_value());
          end else begin
            run_end = left_idx;
            while (run_end + 1 < cur_usable && loaded[run_end + 1]) run_end++;
            right_idx = ($urandom_range(0, 1) == 1) ? run_end
                                                    : $urandom_range(left_idx, run_end);
            send_query(left_idx, right_idx);
          end
        end
      end
      settle();
    end

    $display("Covered %0d items (%0d loads, %0d queries, %0d bad ranges) over %0d settings",
             items_sent, loads_sent, queries_sent, bad_sent, settings_used);
    $display("Checked %0d answers under random stalls, bursts and long hold-offs",
             answers.checked);
    if (answers.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== range_min_max_sum_query.f =====
rtl/rmmsq_pkg.sv
rtl/range_min_max_sum_query.sv
tb/tb_range_min_max_sum_query.sv
